### src/tap_pkg.sv
package tap_pkg;

    localparam int DW  = 32;
    localparam int PW  = 2 * DW;
    localparam int QW  = PW - 16;
    localparam int AW  = 50;
    localparam int PCW = 4;

    localparam int                     TIME_STEP_SHIFT_DEF = 10;
    localparam logic signed [DW-1:0]   INT_LIMIT_MAX_DEF   = 32'sd655360;
    localparam logic signed [DW-1:0]   INT_LIMIT_MIN_DEF   = -32'sd655360;

    localparam logic signed [DW-1:0]   ERR_MIN_RST = -32'sd102944;
    localparam logic signed [DW-1:0]   ERR_MAX_RST = 32'sd102944;

    localparam logic signed [DW-1:0]   S32_MAX = 32'sh7fff_ffff;
    localparam logic signed [DW-1:0]   S32_MIN = 32'sh8000_0000;

    localparam logic [PCW-1:0] PC_LAT_LOOP = 4'd7;

    typedef enum logic [2:0] {
        REG_ERR_MIN = 3'd0,
        REG_ERR_MAX = 3'd1,
        REG_ROLL_KR = 3'd2,
        REG_ROLL_KP = 3'd3,
        REG_ROLL_KI = 3'd4,
        REG_LAT_KR  = 3'd5,
        REG_LAT_KA  = 3'd6,
        REG_LAT_KS  = 3'd7
    } t_reg;

    typedef struct packed {
        logic signed [DW-1:0] roll_error_min;
        logic signed [DW-1:0] roll_error_max;
        logic signed [DW-1:0] roll_rate_gain;
        logic signed [DW-1:0] roll_prop_gain;
        logic signed [DW-1:0] roll_int_gain;
        logic signed [DW-1:0] lateral_rate_gain;
        logic signed [DW-1:0] lateral_accel_gain;
        logic signed [DW-1:0] lateral_output_gain;
    } t_cfg;

    typedef struct packed {
        logic signed [DW-1:0] roll_angle;
        logic signed [DW-1:0] accel_y;
        logic signed [DW-1:0] accel_z;
        logic signed [DW-1:0] roll_rate;
        logic signed [DW-1:0] pitch_rate;
        logic signed [DW-1:0] yaw_rate;
        logic signed [DW-1:0] accel_y_cmd;
        logic signed [DW-1:0] accel_z_cmd;
    } t_item;

    typedef struct packed {
        logic signed [DW-1:0] roll_deflection;
        logic signed [DW-1:0] pitch_deflection;
        logic signed [DW-1:0] yaw_deflection;
        logic                 integrator_limited;
    } t_result;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_KR_P,
        MUL_KP_DAMP,
        MUL_KI_INTEG,
        MUL_LKR_RATE,
        MUL_LKA_ACC,
        MUL_LKS_ERR
    } t_mul;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_LOAD_LIM,
        ACC_LOAD_CMD,
        ACC_CLEAR,
        ACC_ADD,
        ACC_SUB
    } t_acc;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_DAMPED,
        WR_INTEG,
        WR_ROLL,
        WR_ERR,
        WR_LAT
    } t_wr;

    typedef enum logic [1:0] {
        SEQ_NEXT,
        SEQ_LOOP,
        SEQ_END
    } t_seq;

    typedef struct packed {
        t_mul           mul;
        t_acc           acc;
        t_wr            wr;
        t_seq           seq;
        logic [PCW-1:0] target;
    } t_uop;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    localparam t_uop UOP_NOP = '{mul: MUL_NONE, acc: ACC_HOLD, wr: WR_NONE,
                                 seq: SEQ_NEXT, target: '0};

    function automatic t_uop mk(input t_mul m, input t_acc a, input t_wr w,
                                input t_seq s);
        t_uop u;
        u.mul    = m;
        u.acc    = a;
        u.wr     = w;
        u.seq    = s;
        u.target = PC_LAT_LOOP;
        return u;
    endfunction

    // microcode: roll in steps 0-6, lateral loop 7-13 run once per axis
    function automatic t_uop tap_rom(input logic [PCW-1:0] pc);
        t_uop u;
        case (pc)
            4'd0:    u = mk(MUL_KR_P,     ACC_LOAD_LIM, WR_NONE,   SEQ_NEXT);
            4'd1:    u = mk(MUL_NONE,     ACC_SUB,      WR_NONE,   SEQ_NEXT);
            4'd2:    u = mk(MUL_NONE,     ACC_HOLD,     WR_DAMPED, SEQ_NEXT);
            4'd3:    u = mk(MUL_KP_DAMP,  ACC_CLEAR,    WR_INTEG,  SEQ_NEXT);
            4'd4:    u = mk(MUL_KI_INTEG, ACC_ADD,      WR_NONE,   SEQ_NEXT);
            4'd5:    u = mk(MUL_NONE,     ACC_ADD,      WR_NONE,   SEQ_NEXT);
            4'd6:    u = mk(MUL_NONE,     ACC_HOLD,     WR_ROLL,   SEQ_NEXT);
            4'd7:    u = mk(MUL_LKR_RATE, ACC_LOAD_CMD, WR_NONE,   SEQ_NEXT);
            4'd8:    u = mk(MUL_LKA_ACC,  ACC_SUB,      WR_NONE,   SEQ_NEXT);
            4'd9:    u = mk(MUL_NONE,     ACC_SUB,      WR_NONE,   SEQ_NEXT);
            4'd10:   u = mk(MUL_NONE,     ACC_HOLD,     WR_ERR,    SEQ_NEXT);
            4'd11:   u = mk(MUL_LKS_ERR,  ACC_CLEAR,    WR_NONE,   SEQ_NEXT);
            4'd12:   u = mk(MUL_NONE,     ACC_ADD,      WR_NONE,   SEQ_NEXT);
            4'd13:   u = mk(MUL_NONE,     ACC_HOLD,     WR_LAT,    SEQ_LOOP);
            default: u = mk(MUL_NONE,     ACC_HOLD,     WR_NONE,   SEQ_END);
        endcase
        return u;
    endfunction

    function automatic logic signed [DW-1:0] sat32(input logic signed [AW-1:0] x);
        logic signed [AW-1:0] hi;
        logic signed [AW-1:0] lo;
        hi = {{(AW-DW){1'b0}}, S32_MAX};
        lo = {{(AW-DW){1'b1}}, S32_MIN};
        if (x > hi) begin
            return S32_MAX;
        end else if (x < lo) begin
            return S32_MIN;
        end
        return x[DW-1:0];
    endfunction

endpackage

### src/tap_datapath.sv
module tap_datapath #(
    parameter int                   TIME_STEP_SHIFT = tap_pkg::TIME_STEP_SHIFT_DEF,
    parameter logic signed [31:0]   INT_LIMIT_MAX   = tap_pkg::INT_LIMIT_MAX_DEF,
    parameter logic signed [31:0]   INT_LIMIT_MIN   = tap_pkg::INT_LIMIT_MIN_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  tap_pkg::t_item    i_item,
    input  tap_pkg::t_cfg     i_cfg,
    input  tap_pkg::t_uop     i_uop,
    input  logic              i_axis,
    output tap_pkg::t_result  o_result
);

    localparam int DW = tap_pkg::DW;
    localparam int PW = tap_pkg::PW;
    localparam int QW = tap_pkg::QW;
    localparam int AW = tap_pkg::AW;

    tap_pkg::t_item          r_item;
    logic signed [PW-1:0]    r_prod;
    logic signed [AW-1:0]    r_acc;
    logic signed [DW-1:0]    r_damped;
    logic signed [DW-1:0]    r_err;
    logic signed [DW-1:0]    r_integ;
    logic signed [DW-1:0]    r_roll;
    logic signed [DW-1:0]    r_pitch;
    logic signed [DW-1:0]    r_yaw;
    logic                    r_limited;

    logic signed [AW-1:0]    n_acc;
    logic signed [DW-1:0]    w_err;
    logic signed [DW-1:0]    w_lim;
    logic signed [DW-1:0]    w_mul_a;
    logic signed [DW-1:0]    w_mul_b;
    logic signed [PW-1:0]    w_prod;
    logic signed [QW-1:0]    w_pq;
    logic signed [AW-1:0]    w_pq_ext;
    logic signed [DW-1:0]    w_cmd;
    logic signed [DW-1:0]    w_sat;
    logic signed [DW-1:0]    w_inc;
    logic signed [DW:0]      w_sum;
    logic signed [DW:0]      w_imax;
    logic signed [DW:0]      w_imin;

    always_comb begin
        w_err = (r_item.roll_angle == tap_pkg::S32_MIN) ? tap_pkg::S32_MAX
                                                        : -r_item.roll_angle;
        if ($signed(w_err) < $signed(i_cfg.roll_error_min)) begin
            w_lim = i_cfg.roll_error_min;
        end else if ($signed(w_err) > $signed(i_cfg.roll_error_max)) begin
            w_lim = i_cfg.roll_error_max;
        end else begin
            w_lim = w_err;
        end
    end

    always_comb begin
        case (i_uop.mul)
            tap_pkg::MUL_KR_P: begin
                w_mul_a = i_cfg.roll_rate_gain;
                w_mul_b = r_item.roll_rate;
            end
            tap_pkg::MUL_KP_DAMP: begin
                w_mul_a = i_cfg.roll_prop_gain;
                w_mul_b = r_damped;
            end
            tap_pkg::MUL_KI_INTEG: begin
                w_mul_a = i_cfg.roll_int_gain;
                w_mul_b = r_integ;
            end
            tap_pkg::MUL_LKR_RATE: begin
                w_mul_a = i_cfg.lateral_rate_gain;
                w_mul_b = i_axis ? r_item.yaw_rate : r_item.pitch_rate;
            end
            tap_pkg::MUL_LKA_ACC: begin
                w_mul_a = i_cfg.lateral_accel_gain;
                w_mul_b = i_axis ? r_item.accel_z : r_item.accel_y;
            end
            tap_pkg::MUL_LKS_ERR: begin
                w_mul_a = i_cfg.lateral_output_gain;
                w_mul_b = r_err;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod   = $signed(w_mul_a) * $signed(w_mul_b);
    assign w_pq     = $signed(r_prod[PW-1:16]);
    assign w_pq_ext = {{(AW-QW){w_pq[QW-1]}}, w_pq};
    assign w_cmd    = i_axis ? r_item.accel_z_cmd : r_item.accel_y_cmd;
    assign w_sat    = tap_pkg::sat32(r_acc);

    always_comb begin
        case (i_uop.acc)
            tap_pkg::ACC_LOAD_LIM: n_acc = {{(AW-DW){w_lim[DW-1]}}, w_lim};
            tap_pkg::ACC_LOAD_CMD: n_acc = {{(AW-DW){w_cmd[DW-1]}}, w_cmd};
            tap_pkg::ACC_CLEAR:    n_acc = '0;
            tap_pkg::ACC_ADD:      n_acc = r_acc + w_pq_ext;
            tap_pkg::ACC_SUB:      n_acc = r_acc - w_pq_ext;
            default:               n_acc = r_acc;
        endcase
    end

    assign w_inc  = $signed(r_damped) >>> TIME_STEP_SHIFT;
    assign w_sum  = {r_integ[DW-1], r_integ} + {w_inc[DW-1], w_inc};
    assign w_imax = {INT_LIMIT_MAX[DW-1], INT_LIMIT_MAX};
    assign w_imin = {INT_LIMIT_MIN[DW-1], INT_LIMIT_MIN};

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_item;
        end
        r_prod <= w_prod;
        r_acc  <= n_acc;
        case (i_uop.wr)
            tap_pkg::WR_DAMPED: r_damped <= w_sat;
            tap_pkg::WR_ROLL:   r_roll   <= w_sat;
            tap_pkg::WR_ERR:    r_err    <= w_sat;
            tap_pkg::WR_LAT: begin
                if (i_axis) begin
                    r_yaw <= w_sat;
                end else begin
                    r_pitch <= w_sat;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ   <= '0;
            r_limited <= 1'b0;
        end else if (i_uop.wr == tap_pkg::WR_INTEG) begin
            if ($signed(w_sum) > $signed(w_imax)) begin
                r_integ   <= INT_LIMIT_MAX;
                r_limited <= 1'b1;
            end else if ($signed(w_sum) < $signed(w_imin)) begin
                r_integ   <= INT_LIMIT_MIN;
                r_limited <= 1'b1;
            end else begin
                r_integ   <= w_sum[DW-1:0];
                r_limited <= 1'b0;
            end
        end
    end

    assign o_result.roll_deflection    = r_roll;
    assign o_result.pitch_deflection   = r_pitch;
    assign o_result.yaw_deflection     = r_yaw;
    assign o_result.integrator_limited = r_limited;

`ifndef ASSERT_OFF
    a_integ_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($signed(r_integ) <= $signed(INT_LIMIT_MAX))
        && ($signed(r_integ) >= $signed(INT_LIMIT_MIN)))
        else $error("roll integrator outside its limits");
`endif

endmodule

### src/three_axis_autopilot_step.sv
// channel | direction | handshake               | word
// in      | input     | i_in_valid / o_in_stall   | eight Q16.16 sensor and command fields
// out     | output    | o_out_valid / i_out_stall | roll, pitch, yaw deflection, limit flag
// cfg     | input     | i_cfg_valid / o_cfg_ready | register index, 32-bit data
//
// One word runs the idle state and then 22 microcode steps, set by the single
// shared 32x32 multiplier (nine products per word, one step each) and its accumulator.
// The input is stalled while the program runs; a finished word waits in the output
// register, so the next input word is taken while the previous result is still stalled.
// Synchronous active-low reset clears the sequencer and the roll integrator and
// restores the config defaults.
module three_axis_autopilot_step #(
    parameter int                   TIME_STEP_SHIFT = tap_pkg::TIME_STEP_SHIFT_DEF,
    parameter logic signed [31:0]   INT_LIMIT_MAX   = tap_pkg::INT_LIMIT_MAX_DEF,
    parameter logic signed [31:0]   INT_LIMIT_MIN   = tap_pkg::INT_LIMIT_MIN_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [31:0] i_roll_angle,
    input  logic signed [31:0] i_accel_y,
    input  logic signed [31:0] i_accel_z,
    input  logic signed [31:0] i_roll_rate,
    input  logic signed [31:0] i_pitch_rate,
    input  logic signed [31:0] i_yaw_rate,
    input  logic signed [31:0] i_accel_y_cmd,
    input  logic signed [31:0] i_accel_z_cmd,

    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_roll_deflection,
    output logic signed [31:0] o_pitch_deflection,
    output logic signed [31:0] o_yaw_deflection,
    output logic               o_integrator_limited,

    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic signed [31:0] i_cfg_data
);

    localparam int PCW = tap_pkg::PCW;

    tap_pkg::t_state    r_state;
    tap_pkg::t_state    n_state;
    logic [PCW-1:0]     r_pc;
    logic [PCW-1:0]     n_pc;
    logic               r_axis;
    logic               n_axis;
    logic               r_out_valid;
    tap_pkg::t_result   r_out;
    tap_pkg::t_cfg      r_cfg;

    logic               w_in_accept;
    logic               w_out_load;
    tap_pkg::t_uop      w_rom;
    tap_pkg::t_uop      w_uop;
    tap_pkg::t_item     w_item;
    tap_pkg::t_result   w_result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.roll_error_min      <= tap_pkg::ERR_MIN_RST;
            r_cfg.roll_error_max      <= tap_pkg::ERR_MAX_RST;
            r_cfg.roll_rate_gain      <= '0;
            r_cfg.roll_prop_gain      <= '0;
            r_cfg.roll_int_gain       <= '0;
            r_cfg.lateral_rate_gain   <= '0;
            r_cfg.lateral_accel_gain  <= '0;
            r_cfg.lateral_output_gain <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (tap_pkg::t_reg'(i_cfg_index))
                tap_pkg::REG_ERR_MIN: r_cfg.roll_error_min      <= i_cfg_data;
                tap_pkg::REG_ERR_MAX: r_cfg.roll_error_max      <= i_cfg_data;
                tap_pkg::REG_ROLL_KR: r_cfg.roll_rate_gain      <= i_cfg_data;
                tap_pkg::REG_ROLL_KP: r_cfg.roll_prop_gain      <= i_cfg_data;
                tap_pkg::REG_ROLL_KI: r_cfg.roll_int_gain       <= i_cfg_data;
                tap_pkg::REG_LAT_KR:  r_cfg.lateral_rate_gain   <= i_cfg_data;
                tap_pkg::REG_LAT_KA:  r_cfg.lateral_accel_gain  <= i_cfg_data;
                tap_pkg::REG_LAT_KS:  r_cfg.lateral_output_gain <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_in_stall  = (r_state != tap_pkg::ST_IDLE);
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_rom       = tap_pkg::tap_rom(r_pc);
    assign w_uop       = (r_state == tap_pkg::ST_RUN) ? w_rom : tap_pkg::UOP_NOP;

    always_comb begin
        n_state    = r_state;
        n_pc       = r_pc;
        n_axis     = r_axis;
        w_out_load = 1'b0;
        case (r_state)
            tap_pkg::ST_IDLE: begin
                if (w_in_accept) begin
                    n_state = tap_pkg::ST_RUN;
                    n_pc    = '0;
                    n_axis  = 1'b0;
                end
            end
            tap_pkg::ST_RUN: begin
                case (w_rom.seq)
                    tap_pkg::SEQ_LOOP: begin
                        if (!r_axis) begin
                            n_pc   = w_rom.target;
                            n_axis = 1'b1;
                        end else begin
                            n_pc = r_pc + 1'b1;
                        end
                    end
                    tap_pkg::SEQ_END: begin
                        if (!r_out_valid || !i_out_stall) begin
                            w_out_load = 1'b1;
                            n_state    = tap_pkg::ST_IDLE;
                        end
                    end
                    default: n_pc = r_pc + 1'b1;
                endcase
            end
            default: n_state = tap_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tap_pkg::ST_IDLE;
            r_pc        <= '0;
            r_axis      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_axis  <= n_axis;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out <= w_result;
        end
    end

    assign w_item.roll_angle  = i_roll_angle;
    assign w_item.accel_y     = i_accel_y;
    assign w_item.accel_z     = i_accel_z;
    assign w_item.roll_rate   = i_roll_rate;
    assign w_item.pitch_rate  = i_pitch_rate;
    assign w_item.yaw_rate    = i_yaw_rate;
    assign w_item.accel_y_cmd = i_accel_y_cmd;
    assign w_item.accel_z_cmd = i_accel_z_cmd;

    tap_datapath #(
        .TIME_STEP_SHIFT (TIME_STEP_SHIFT),
        .INT_LIMIT_MAX   (INT_LIMIT_MAX),
        .INT_LIMIT_MIN   (INT_LIMIT_MIN)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_in_accept),
        .i_item   (w_item),
        .i_cfg    (r_cfg),
        .i_uop    (w_uop),
        .i_axis   (r_axis),
        .o_result (w_result)
    );

    assign o_out_valid          = r_out_valid;
    assign o_roll_deflection    = r_out.roll_deflection;
    assign o_pitch_deflection   = r_out.pitch_deflection;
    assign o_yaw_deflection     = r_out.yaw_deflection;
    assign o_integrator_limited = r_out.integrator_limited;

`ifndef ASSERT_OFF
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept |=> (r_state == tap_pkg::ST_RUN) && (r_pc == '0) && !r_axis)
        else $error("accepted word did not start the program");
    a_result_from_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |-> (r_state == tap_pkg::ST_RUN) && r_axis)
        else $error("result loaded before both lateral passes");
    a_loop_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == tap_pkg::ST_RUN) && (w_rom.seq == tap_pkg::SEQ_LOOP) && !r_axis)
        |=> (r_pc == tap_pkg::PC_LAT_LOOP) && r_axis)
        else $error("lateral loop did not rerun for yaw");
`endif

endmodule
